FILE: rtl/space_vector_pwm_duty_defines.svh
// Assertion macros for the space vector PWM duty block.
// Used by space_vector_pwm_duty; relies on clk and rst_n being in scope.
`ifndef SPACE_VECTOR_PWM_DUTY_DEFINES_SVH
`define SPACE_VECTOR_PWM_DUTY_DEFINES_SVH

// Same-cycle implication, checked while out of reset
`define SVPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset
`define SVPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/svpd_pkg.sv
// Shared constants and types for the space vector PWM duty pipeline.
// No dependencies; imported by every module of the block.
package svpd_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_VOLTAGE_LIMIT = 2'd0,
        REG_UNITY_DUTY    = 2'd1,
        REG_ANGLE_OFFSET  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } sector_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [14:0] VLIM_RESET   = 15'd6144;
    localparam logic [13:0] UNITY_RESET  = 14'd512;
    localparam logic [11:0] OFFSET_RESET = 12'd1024;

    // sector boundaries over one turn of 4096 steps
    localparam logic [11:0] SECTOR_BOUND [6] =
        '{12'd683, 12'd1365, 12'd2048, 12'd2731, 12'd3413, 12'd4095};

    // sine argument: at most 683 steps times 8
    localparam int X_W    = 13;
    localparam int PROD_W = 31;
    localparam int QUO_W  = 32;

    // polynomial sine coefficients
    localparam logic [31:0] SIN_CA    = 32'd292421;
    localparam logic [31:0] SIN_K2    = 32'd2746362156;
    localparam logic [31:0] SIN_K1    = 32'd3370945099;
    localparam logic [31:0] SIN_ROUND = 32'h0004_0000;
    localparam logic [22:0] SQRT3_Q9  = 23'd887;

    localparam int SINE_LAT   = 7;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;
    localparam int DIV_LAT    = DIV_STAGES + 2;
    localparam int SEC_DEPTH  = SINE_LAT + DIV_LAT + 1;
    localparam int PIPE_LAT   = SEC_DEPTH + 3;

endpackage

FILE: rtl/space_vector_pwm_duty.sv
// Space vector PWM duty: entry, sine, divider, duty, product and output stages.
// Throughput one transaction per cycle; the pipeline holds as a whole while
// the output transaction is stalled. The sine and divider stages set the depth.
// Reset clears all valid bits and loads the configuration reset values.
// Depends on svpd_pkg, svpd_sine, svpd_div and the defines header.
`include "space_vector_pwm_duty_defines.svh"
module space_vector_pwm_duty (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [svpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [svpd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [15:0]                 voltage_cmd,
    input  logic [15:0]                        rotor_angle,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [15:0]                 phase_a,
    output logic signed [15:0]                 phase_b,
    output logic signed [15:0]                 phase_c
);
    import svpd_pkg::*;

    logic [14:0] vlim_reg;
    logic [13:0] unity_reg;
    logic [11:0] offset_reg;

    logic [PIPE_LAT-1:0] vld_reg;
    logic                en;

    sector_t            sec_reg [SEC_DEPTH];
    logic [X_W-1:0]     x1_reg, x2_reg;
    logic signed [15:0] cmd_reg;

    logic [11:0]  ang;
    sector_t      sec_next;
    logic [11:0]  hi, lo, d1, d2;

    logic signed [PROD_W-1:0] prod1, prod2;
    logic signed [QUO_W-1:0]  t1, t2;
    logic [14:0]              divisor;

    logic signed [33:0] t0, h, sum, t1e, t2e;
    logic signed [34:0] ta_next, tb_next, tc_next;
    logic signed [34:0] ta_reg, tb_reg, tc_reg;
    logic signed [50:0] pa_reg, pb_reg, pc_reg;
    logic signed [50:0] vl_ext, adj_a, adj_b, adj_c;
    logic signed [15:0] pha_reg, phb_reg, phc_reg;

    // pipeline moves unless the output transaction is held
    assign en       = !(vld_reg[PIPE_LAT-1] && out_stall);
    assign in_stall = !en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlim_reg   <= VLIM_RESET;
            unity_reg  <= UNITY_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_VOLTAGE_LIMIT: vlim_reg   <= cfg_data;
                REG_UNITY_DUTY:    unity_reg  <= cfg_data[13:0];
                REG_ANGLE_OFFSET:  offset_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], in_valid};
        end
    end

    // reduce angle, pick sector and sector-relative arguments
    always_comb
    begin
        ang      = rotor_angle[11:0] + offset_reg;
        sec_next = SEC_5;
        for (int i = 4; i >= 0; i--)
        begin
            if (ang <= SECTOR_BOUND[i])
            begin
                sec_next = sector_t'(3'(i));
            end
        end
        hi = SECTOR_BOUND[sec_next];
        lo = (sec_next == SEC_0) ? 12'd0 : SECTOR_BOUND[3'(sec_next - 3'd1)];
        d1 = hi - ang;
        d2 = ang - lo;
    end

    // entry stage and sector delay line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg     <= {d1[9:0], 3'b000};
            x2_reg     <= {d2[9:0], 3'b000};
            cmd_reg    <= voltage_cmd;
            sec_reg[0] <= sec_next;
            for (int i = 1; i < SEC_DEPTH; i++)
            begin
                sec_reg[i] <= sec_reg[i-1];
            end
        end
    end

    svpd_sine u_sine1 (.clk(clk), .en(en), .x(x1_reg), .cmd(cmd_reg), .prod(prod1));
    svpd_sine u_sine2 (.clk(clk), .en(en), .x(x2_reg), .cmd(cmd_reg), .prod(prod2));

    assign divisor = (vlim_reg == '0) ? 15'd1 : vlim_reg;

    svpd_div u_div1 (.clk(clk), .en(en), .dividend(prod1), .divisor(divisor), .quo(t1));
    svpd_div u_div2 (.clk(clk), .en(en), .dividend(prod2), .divisor(divisor), .quo(t2));

    // zero vector time and sector duty sums
    always_comb
    begin
        t1e = 34'(t1);
        t2e = 34'(t2);
        t0  = $signed({20'b0, unity_reg}) - t1e - t2e;
        h   = (t0 + $signed({33'b0, t0[33]})) >>> 1;
        sum = t1e + t2e;
        case (sec_reg[SEC_DEPTH-1])
            SEC_0:
            begin
                ta_next = 35'(sum) + 35'(h); tb_next = 35'(t2e) + 35'(h); tc_next = 35'(h);
            end
            SEC_1:
            begin
                ta_next = 35'(t1e) + 35'(h); tb_next = 35'(sum) + 35'(h); tc_next = 35'(h);
            end
            SEC_2:
            begin
                ta_next = 35'(h); tb_next = 35'(sum) + 35'(h); tc_next = 35'(t2e) + 35'(h);
            end
            SEC_3:
            begin
                ta_next = 35'(h); tb_next = 35'(t1e) + 35'(h); tc_next = 35'(sum) + 35'(h);
            end
            SEC_4:
            begin
                ta_next = 35'(t2e) + 35'(h); tb_next = 35'(h); tc_next = 35'(sum) + 35'(h);
            end
            default:
            begin
                ta_next = 35'(sum) + 35'(h); tb_next = 35'(h); tc_next = 35'(t1e) + 35'(h);
            end
        endcase
    end

    // scale back by the voltage limit, truncate toward zero
    always_comb
    begin
        vl_ext = $signed({36'b0, vlim_reg});
        adj_a  = pa_reg + (pa_reg[50] ? 51'sd511 : 51'sd0);
        adj_b  = pb_reg + (pb_reg[50] ? 51'sd511 : 51'sd0);
        adj_c  = pc_reg + (pc_reg[50] ? 51'sd511 : 51'sd0);
    end

    // duty, product and output stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta_reg  <= ta_next;
            tb_reg  <= tb_next;
            tc_reg  <= tc_next;
            pa_reg  <= 51'(ta_reg) * vl_ext;
            pb_reg  <= 51'(tb_reg) * vl_ext;
            pc_reg  <= 51'(tc_reg) * vl_ext;
            pha_reg <= adj_a[24:9];
            phb_reg <= adj_b[24:9];
            phc_reg <= adj_c[24:9];
        end
    end

    assign out_valid = vld_reg[PIPE_LAT-1];
    assign phase_a   = pha_reg;
    assign phase_b   = phb_reg;
    assign phase_c   = phc_reg;

    `SVPD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output hold")
    `SVPD_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld_reg[0], "accepted transaction lost at entry")
    `SVPD_ASSERT_NEXT(a_hold_valids, in_stall, $stable(vld_reg), "valid bits moved during hold")
    `SVPD_ASSERT_NOW(a_divisor_nonzero, 1'b1, divisor != 15'd0, "divisor is zero")

endmodule

FILE: rtl/svpd_sine.sv
// One sine lane: fixed-point polynomial sine, sqrt(3) scale and command product.
// Depends on svpd_pkg. Seven register stages, one multiply per stage.
module svpd_sine (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [svpd_pkg::X_W-1:0]              x,
    input  logic signed [15:0]                    cmd,
    output logic signed [svpd_pkg::PROD_W-1:0]    prod
);
    import svpd_pkg::*;

    logic [X_W-1:0]     x_reg   [4];
    logic signed [15:0] cmd_reg [6];
    logic [31:0]        p1_reg, p2_reg, p3_reg, p4_reg, p6_reg;
    logic [22:0]        sc_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic [31:0] y2, y5, y6r;
    logic [13:0] sp;

    // intermediate polynomial terms
    always_comb
    begin
        y2  = SIN_K2 - {3'b0, p2_reg[31:3]};
        y5  = SIN_K1 - {1'b0, p4_reg[31:1]};
        y6r = p6_reg + SIN_ROUND;
        sp  = sc_reg[22:9];
    end

    // advance the lane
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= x;
            cmd_reg[0] <= cmd;
            for (int i = 1; i < 4; i++)
            begin
                x_reg[i] <= x_reg[i-1];
            end
            for (int i = 1; i < 6; i++)
            begin
                cmd_reg[i] <= cmd_reg[i-1];
            end
            p1_reg   <= SIN_CA * {19'b0, x};
            p2_reg   <= {19'b0, x_reg[0]} * {13'b0, p1_reg[31:13]};
            p3_reg   <= {19'b0, x_reg[1]} * {13'b0, y2[31:13]};
            p4_reg   <= {19'b0, x_reg[2]} * {13'b0, p3_reg[31:13]};
            p6_reg   <= {19'b0, x_reg[3]} * {13'b0, y5[31:13]};
            sc_reg   <= SQRT3_Q9 * {10'b0, y6r[31:19]};
            prod_reg <= $signed({17'b0, sp}) * $signed({{15{cmd_reg[5][15]}}, cmd_reg[5]});
        end
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/svpd_div.sv
// Pipelined signed divider, quotient truncated toward zero.
// Depends on svpd_pkg. Sign stage, DIV_STAGES radix-2 stages, sign fix stage.
module svpd_div (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [svpd_pkg::PROD_W-1:0]   dividend,
    input  logic [14:0]                          divisor,
    output logic signed [svpd_pkg::QUO_W-1:0]    quo
);
    import svpd_pkg::*;

    logic [QUO_W-1:0] dq_reg  [DIV_STAGES+1];
    logic [14:0]      rem_reg [DIV_STAGES+1];
    logic             neg_reg [DIV_STAGES+1];
    logic [QUO_W-1:0] dq_next [DIV_STAGES+1];
    logic [14:0]      rem_next[DIV_STAGES+1];
    logic signed [QUO_W-1:0] quo_reg;
    logic [QUO_W-1:0] ext;

    // split sign and magnitude
    always_comb
    begin
        ext         = QUO_W'(dividend);
        dq_next[0]  = dividend[PROD_W-1] ? (~ext + 1'b1) : ext;
        rem_next[0] = '0;
    end

    // shift-subtract steps, DIV_STEPS per stage
    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_stage
        logic [15:0]      rr;
        logic [14:0]      r;
        logic [QUO_W-1:0] q;
        always_comb
        begin
            r  = rem_reg[s-1];
            q  = dq_reg[s-1];
            rr = '0;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                rr = {r, q[QUO_W-1]};
                q  = {q[QUO_W-2:0], 1'b0};
                if (rr >= {1'b0, divisor})
                begin
                    r    = 15'(rr - {1'b0, divisor});
                    q[0] = 1'b1;
                end
                else
                begin
                    r = rr[14:0];
                end
            end
            dq_next[s]  = q;
            rem_next[s] = r;
        end
    end

    // advance the divider stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dq_reg[0]  <= dq_next[0];
            rem_reg[0] <= rem_next[0];
            neg_reg[0] <= dividend[PROD_W-1];
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                dq_reg[s]  <= dq_next[s];
                rem_reg[s] <= rem_next[s];
                neg_reg[s] <= neg_reg[s-1];
            end
            quo_reg <= neg_reg[DIV_STAGES] ? $signed(~dq_reg[DIV_STAGES] + 1'b1)
                                           : $signed(dq_reg[DIV_STAGES]);
        end
    end

    assign quo = quo_reg;

endmodule
